// ===== rtl/core/mid_pkg.sv =====
// Types, codes and decode tables shared by the instruction decoder.
// The interfaces, the decode logic and the top level all import this package.
package mid_pkg;

  localparam int WORD_W  = 32;
  localparam int OP_W    = 6;
  localparam int REG_W   = 5;
  localparam int FN_W    = 6;
  localparam int IMM_W   = 16;
  localparam int JT_W    = 26;
  localparam int CLASS_W = 6;

  localparam logic [REG_W-1:0] LINK_REG = 5'd31;

  localparam logic [CLASS_W-1:0] CLS_ILLEGAL = 6'd0;
  localparam logic [CLASS_W-1:0] CLS_ADD     = 6'd1;
  localparam logic [CLASS_W-1:0] CLS_ADDU    = 6'd2;
  localparam logic [CLASS_W-1:0] CLS_SUB     = 6'd3;
  localparam logic [CLASS_W-1:0] CLS_AND     = 6'd4;
  localparam logic [CLASS_W-1:0] CLS_OR      = 6'd5;
  localparam logic [CLASS_W-1:0] CLS_XOR     = 6'd6;
  localparam logic [CLASS_W-1:0] CLS_NOR     = 6'd7;
  localparam logic [CLASS_W-1:0] CLS_NAND    = 6'd8;
  localparam logic [CLASS_W-1:0] CLS_SLT     = 6'd9;
  localparam logic [CLASS_W-1:0] CLS_SLL     = 6'd10;
  localparam logic [CLASS_W-1:0] CLS_NOP     = 6'd11;
  localparam logic [CLASS_W-1:0] CLS_SRL     = 6'd12;
  localparam logic [CLASS_W-1:0] CLS_SRA     = 6'd13;
  localparam logic [CLASS_W-1:0] CLS_JR      = 6'd14;
  localparam logic [CLASS_W-1:0] CLS_MULT    = 6'd15;
  localparam logic [CLASS_W-1:0] CLS_MULTU   = 6'd16;
  localparam logic [CLASS_W-1:0] CLS_MFHI    = 6'd17;
  localparam logic [CLASS_W-1:0] CLS_MFLO    = 6'd18;
  localparam logic [CLASS_W-1:0] CLS_ADDI    = 6'd19;
  localparam logic [CLASS_W-1:0] CLS_ADDIU   = 6'd20;
  localparam logic [CLASS_W-1:0] CLS_LW      = 6'd21;
  localparam logic [CLASS_W-1:0] CLS_LH      = 6'd22;
  localparam logic [CLASS_W-1:0] CLS_LHU     = 6'd23;
  localparam logic [CLASS_W-1:0] CLS_LB      = 6'd24;
  localparam logic [CLASS_W-1:0] CLS_LBU     = 6'd25;
  localparam logic [CLASS_W-1:0] CLS_SW      = 6'd26;
  localparam logic [CLASS_W-1:0] CLS_SH      = 6'd27;
  localparam logic [CLASS_W-1:0] CLS_SB      = 6'd28;
  localparam logic [CLASS_W-1:0] CLS_LUI     = 6'd29;
  localparam logic [CLASS_W-1:0] CLS_ANDI    = 6'd30;
  localparam logic [CLASS_W-1:0] CLS_ORI     = 6'd31;
  localparam logic [CLASS_W-1:0] CLS_NORI    = 6'd32;
  localparam logic [CLASS_W-1:0] CLS_SLTI    = 6'd33;
  localparam logic [CLASS_W-1:0] CLS_BEQ     = 6'd34;
  localparam logic [CLASS_W-1:0] CLS_BNE     = 6'd35;
  localparam logic [CLASS_W-1:0] CLS_BGTZ    = 6'd36;
  localparam logic [CLASS_W-1:0] CLS_J       = 6'd37;
  localparam logic [CLASS_W-1:0] CLS_JAL     = 6'd38;
  localparam logic [CLASS_W-1:0] CLS_HALT    = 6'd39;

  localparam logic [OP_W-1:0] OP_SPECIAL = 6'h00;
  localparam logic [OP_W-1:0] OP_J       = 6'h02;
  localparam logic [OP_W-1:0] OP_JAL     = 6'h03;
  localparam logic [OP_W-1:0] OP_BEQ     = 6'h04;
  localparam logic [OP_W-1:0] OP_BNE     = 6'h05;
  localparam logic [OP_W-1:0] OP_BGTZ    = 6'h07;
  localparam logic [OP_W-1:0] OP_ADDI    = 6'h08;
  localparam logic [OP_W-1:0] OP_ADDIU   = 6'h09;
  localparam logic [OP_W-1:0] OP_SLTI    = 6'h0a;
  localparam logic [OP_W-1:0] OP_ANDI    = 6'h0c;
  localparam logic [OP_W-1:0] OP_ORI     = 6'h0d;
  localparam logic [OP_W-1:0] OP_NORI    = 6'h0e;
  localparam logic [OP_W-1:0] OP_LUI     = 6'h0f;
  localparam logic [OP_W-1:0] OP_LB      = 6'h20;
  localparam logic [OP_W-1:0] OP_LH      = 6'h21;
  localparam logic [OP_W-1:0] OP_LW      = 6'h23;
  localparam logic [OP_W-1:0] OP_LBU     = 6'h24;
  localparam logic [OP_W-1:0] OP_LHU     = 6'h25;
  localparam logic [OP_W-1:0] OP_SB      = 6'h28;
  localparam logic [OP_W-1:0] OP_SH      = 6'h29;
  localparam logic [OP_W-1:0] OP_SW      = 6'h2b;
  localparam logic [OP_W-1:0] OP_HALT    = 6'h3f;

  localparam logic [FN_W-1:0] FN_SLL   = 6'h00;
  localparam logic [FN_W-1:0] FN_SRL   = 6'h02;
  localparam logic [FN_W-1:0] FN_SRA   = 6'h03;
  localparam logic [FN_W-1:0] FN_JR    = 6'h08;
  localparam logic [FN_W-1:0] FN_MFHI  = 6'h10;
  localparam logic [FN_W-1:0] FN_MFLO  = 6'h12;
  localparam logic [FN_W-1:0] FN_MULT  = 6'h18;
  localparam logic [FN_W-1:0] FN_MULTU = 6'h19;
  localparam logic [FN_W-1:0] FN_ADD   = 6'h20;
  localparam logic [FN_W-1:0] FN_ADDU  = 6'h21;
  localparam logic [FN_W-1:0] FN_SUB   = 6'h22;
  localparam logic [FN_W-1:0] FN_AND   = 6'h24;
  localparam logic [FN_W-1:0] FN_OR    = 6'h25;
  localparam logic [FN_W-1:0] FN_XOR   = 6'h26;
  localparam logic [FN_W-1:0] FN_NOR   = 6'h27;
  localparam logic [FN_W-1:0] FN_NAND  = 6'h28;
  localparam logic [FN_W-1:0] FN_SLT   = 6'h2a;

  typedef struct packed {
    logic [CLASS_W-1:0]      inst_class;
    logic                    illegal;
    logic [REG_W-1:0]        dest_reg;
    logic [OP_W-1:0]         op_field;
    logic [REG_W-1:0]        src_reg;
    logic [REG_W-1:0]        tgt_reg;
    logic [REG_W-1:0]        rd_field;
    logic [REG_W-1:0]        shift_amount;
    logic [FN_W-1:0]         func_field;
    logic [IMM_W-1:0]        imm_raw;
    logic signed [IMM_W-1:0] imm_signed;
    logic [JT_W-1:0]         jump_target;
  } mid_result_t;

  function automatic logic [CLASS_W-1:0] rtype_class(input logic [FN_W-1:0] fn);
    logic [CLASS_W-1:0] cls;
    case (fn)
      FN_ADD:   cls = CLS_ADD;
      FN_ADDU:  cls = CLS_ADDU;
      FN_SUB:   cls = CLS_SUB;
      FN_AND:   cls = CLS_AND;
      FN_OR:    cls = CLS_OR;
      FN_XOR:   cls = CLS_XOR;
      FN_NOR:   cls = CLS_NOR;
      FN_NAND:  cls = CLS_NAND;
      FN_SLT:   cls = CLS_SLT;
      FN_SLL:   cls = CLS_SLL;
      FN_SRL:   cls = CLS_SRL;
      FN_SRA:   cls = CLS_SRA;
      FN_JR:    cls = CLS_JR;
      FN_MULT:  cls = CLS_MULT;
      FN_MULTU: cls = CLS_MULTU;
      FN_MFHI:  cls = CLS_MFHI;
      FN_MFLO:  cls = CLS_MFLO;
      default:  cls = CLS_ILLEGAL;
    endcase
    return cls;
  endfunction

  function automatic logic [CLASS_W-1:0] op_class(input logic [OP_W-1:0] op);
    logic [CLASS_W-1:0] cls;
    case (op)
      OP_ADDI:  cls = CLS_ADDI;
      OP_ADDIU: cls = CLS_ADDIU;
      OP_LW:    cls = CLS_LW;
      OP_LH:    cls = CLS_LH;
      OP_LHU:   cls = CLS_LHU;
      OP_LB:    cls = CLS_LB;
      OP_LBU:   cls = CLS_LBU;
      OP_SW:    cls = CLS_SW;
      OP_SH:    cls = CLS_SH;
      OP_SB:    cls = CLS_SB;
      OP_LUI:   cls = CLS_LUI;
      OP_ANDI:  cls = CLS_ANDI;
      OP_ORI:   cls = CLS_ORI;
      OP_NORI:  cls = CLS_NORI;
      OP_SLTI:  cls = CLS_SLTI;
      OP_BEQ:   cls = CLS_BEQ;
      OP_BNE:   cls = CLS_BNE;
      OP_BGTZ:  cls = CLS_BGTZ;
      OP_J:     cls = CLS_J;
      OP_JAL:   cls = CLS_JAL;
      OP_HALT:  cls = CLS_HALT;
      default:  cls = CLS_ILLEGAL;
    endcase
    return cls;
  endfunction

endpackage

// ===== rtl/core/mid_if.sv =====
// Valid/ready channel interfaces for instruction words and decoded results.
// Depends on mid_pkg for the field widths.
interface mid_instr_if;
  import mid_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] instr_word;
  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface mid_dec_if;
  import mid_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CLASS_W-1:0]      inst_class;
  logic                    illegal;
  logic [REG_W-1:0]        dest_reg;
  logic [OP_W-1:0]         op_field;
  logic [REG_W-1:0]        src_reg;
  logic [REG_W-1:0]        tgt_reg;
  logic [REG_W-1:0]        rd_field;
  logic [REG_W-1:0]        shift_amount;
  logic [FN_W-1:0]         func_field;
  logic [IMM_W-1:0]        imm_raw;
  logic signed [IMM_W-1:0] imm_signed;
  logic [JT_W-1:0]         jump_target;
  modport source (output valid, output inst_class, output illegal, output dest_reg,
                  output op_field, output src_reg, output tgt_reg, output rd_field,
                  output shift_amount, output func_field, output imm_raw,
                  output imm_signed, output jump_target, input ready);
  modport sink (input valid, input inst_class, input illegal, input dest_reg,
                input op_field, input src_reg, input tgt_reg, input rd_field,
                input shift_amount, input func_field, input imm_raw,
                input imm_signed, input jump_target, output ready);
endinterface

// ===== rtl/core/mid_decode.sv =====
// Combinational decode of one instruction word into fields, class and destination.
// Depends on mid_pkg for the codes, tables and result type.
module mid_decode (
  input  logic [mid_pkg::WORD_W-1:0] word,
  output mid_pkg::mid_result_t       result
);
  import mid_pkg::*;

  logic [OP_W-1:0]    op;
  logic [REG_W-1:0]   rt;
  logic [REG_W-1:0]   rd;
  logic [REG_W-1:0]   sh;
  logic [FN_W-1:0]    fn;
  logic [CLASS_W-1:0] cls;
  logic [REG_W-1:0]   dest;

  assign op = word[31:26];
  assign rt = word[20:16];
  assign rd = word[15:11];
  assign sh = word[10:6];
  assign fn = word[5:0];

  always_comb begin
    if (op == OP_SPECIAL) begin
      if (fn == FN_SLL && rt == '0 && rd == '0 && sh == '0) begin
        cls = CLS_NOP;
      end else begin
        cls = rtype_class(fn);
      end
    end else begin
      cls = op_class(op);
    end
  end

  always_comb begin
    case (cls)
      CLS_ADD, CLS_ADDU, CLS_SUB, CLS_AND, CLS_OR, CLS_XOR, CLS_NOR, CLS_NAND,
      CLS_SLT, CLS_SLL, CLS_NOP, CLS_SRL, CLS_SRA, CLS_MFHI, CLS_MFLO: begin
        dest = rd;
      end
      CLS_JAL: begin
        dest = LINK_REG;
      end
      default: begin
        dest = rt;
      end
    endcase
  end

  always_comb begin
    result.inst_class   = cls;
    result.illegal      = (cls == CLS_ILLEGAL);
    result.dest_reg     = dest;
    result.op_field     = op;
    result.src_reg      = word[25:21];
    result.tgt_reg      = rt;
    result.rd_field     = rd;
    result.shift_amount = sh;
    result.func_field   = fn;
    result.imm_raw      = word[15:0];
    result.imm_signed   = signed'(word[15:0]);
    result.jump_target  = word[25:0];
  end

endmodule

// ===== rtl/core/mips_instruction_decoder_core.sv =====
// Top level of the instruction decoder: input register, decode logic, result register.
// Depends on mid_pkg, the channel interfaces in mid_if and mid_decode.
//
//   Port     Direction  Transaction
//   instr    in         one 32-bit instruction word
//   decoded  out        class, illegal flag, destination and raw fields of one word
//
// Each transaction passes through the input register and then the result register.
// A new word is accepted every cycle; the only limit is the result register.
// A stall on decoded fills the two registers and then holds instr.ready low.
// Synchronous reset empties both registers; payload registers are not reset.
module mips_instruction_decoder_core (
  input logic         clk,
  input logic         rst,
  mid_instr_if.sink   instr,
  mid_dec_if.source   decoded
);
  import mid_pkg::*;

  logic              word_valid;
  logic [WORD_W-1:0] word;
  logic              res_valid;
  mid_result_t       res;
  mid_result_t       res_next;
  logic              res_free;

  assign res_free    = !res_valid || decoded.ready;
  assign instr.ready = !word_valid || res_free;

  mid_decode u_decode (
    .word   (word),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (instr.ready) begin
        word_valid <= instr.valid;
      end
      if (res_free) begin
        res_valid <= word_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      word <= instr.instr_word;
    end
    if (res_free && word_valid) begin
      res <= res_next;
    end
  end

  assign decoded.valid        = res_valid;
  assign decoded.inst_class   = res.inst_class;
  assign decoded.illegal      = res.illegal;
  assign decoded.dest_reg     = res.dest_reg;
  assign decoded.op_field     = res.op_field;
  assign decoded.src_reg      = res.src_reg;
  assign decoded.tgt_reg      = res.tgt_reg;
  assign decoded.rd_field     = res.rd_field;
  assign decoded.shift_amount = res.shift_amount;
  assign decoded.func_field   = res.func_field;
  assign decoded.imm_raw      = res.imm_raw;
  assign decoded.imm_signed   = res.imm_signed;
  assign decoded.jump_target  = res.jump_target;

  a_illegal_class : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.illegal == (res.inst_class == CLS_ILLEGAL)))
    else $error("illegal flag disagrees with class");

  a_jal_link : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.inst_class == CLS_JAL) |-> (res.dest_reg == LINK_REG))
    else $error("JAL does not write the link register");

  a_fields_agree : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.jump_target[25:21] == res.src_reg &&
                   res.jump_target[15:0] == res.imm_raw))
    else $error("decoded fields come from different words");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> (!res_valid && !word_valid))
    else $error("pipeline not empty after reset");

endmodule
